// ===== rtl/core/elc_pkg.sv =====
// ----------------------------------------------------------------------------
// Elevator controller package
// Shared types, state codes, lamp positions and reset constants for the
// three-floor car controller.
// ----------------------------------------------------------------------------
package elc_pkg;

    localparam int PIN_W   = 16;
    localparam int LAMP_W  = 12;
    localparam int DRIVE_W = 2;
    localparam int STATE_W = 4;
    localparam int HOLD_W  = 16;

    localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd5000;

    // Positions of the latched request lamps
    localparam int L_DOOR = 0;
    localparam int L_F1IN = 1;
    localparam int L_F2IN = 2;
    localparam int L_F3IN = 3;
    localparam int L_F1UP = 8;
    localparam int L_F2UP = 9;
    localparam int L_F2DN = 10;
    localparam int L_F3DN = 11;

    // Positions of the sampled pins
    localparam int PIN_DONE = 10;
    localparam int PIN_MID  = 11;
    localparam int PIN_REQ  = 14;
    localparam int PIN_F1IN = 15;

    // Drive latch codes
    localparam logic [DRIVE_W-1:0] DRIVE_IDLE  = 2'd0;
    localparam logic [DRIVE_W-1:0] DRIVE_MOTOR = 2'd2;
    localparam logic [DRIVE_W-1:0] DRIVE_DOOR  = 2'd3;

    typedef enum logic [STATE_W-1:0] {
        ST_F3_CLOSED  = 4'd0,
        ST_F3_OPENING = 4'd1,
        ST_F3_CLOSING = 4'd2,
        ST_F3_OPEN    = 4'd3,
        ST_F2_CLOSED  = 4'd4,
        ST_F2_OPENING = 4'd5,
        ST_F2_CLOSING = 4'd6,
        ST_F2_OPEN    = 4'd7,
        ST_F1_CLOSED  = 4'd8,
        ST_F1_OPENING = 4'd9,
        ST_F1_CLOSING = 4'd10,
        ST_F1_OPEN    = 4'd11,
        ST_DOWN_25    = 4'd12,
        ST_DOWN_15    = 4'd13,
        ST_UP_15      = 4'd14,
        ST_UP_25      = 4'd15
    } car_state_t;

    // Controller state carried from one tick to the next
    typedef struct packed {
        car_state_t          car_state;
        logic [LAMP_W-1:0]   lamps;
        logic [HOLD_W-1:0]   door_timer;
        logic                restarted;
        logic [DRIVE_W-1:0]  drive;
    } ctrl_state_t;

    localparam ctrl_state_t CTRL_RESET = '{
        car_state:  ST_F1_CLOSED,
        lamps:      '0,
        door_timer: '0,
        restarted:  1'b0,
        drive:      DRIVE_IDLE
    };

endpackage

// ===== rtl/core/elc_step.sv =====
// ----------------------------------------------------------------------------
// Elevator controller step logic
// Latches call requests from one pin sample and computes the next controller
// state, lamp vector, door timer and drive latch for one tick.
// ----------------------------------------------------------------------------
module elc_step (
    input  logic [elc_pkg::PIN_W-1:0]  pins,
    input  logic [elc_pkg::HOLD_W-1:0] door_hold,
    input  elc_pkg::ctrl_state_t       cur,
    output elc_pkg::ctrl_state_t       nxt
);

    logic                        done;
    logic                        mid;
    logic                        req;
    logic [elc_pkg::LAMP_W-1:0]  lat;
    logic                        f2_any;

    assign done = pins[elc_pkg::PIN_DONE];
    assign mid  = pins[elc_pkg::PIN_MID];
    assign req  = pins[elc_pkg::PIN_REQ];

    // Latch new calls before the state decision looks at the lamps
    always_comb
    begin
        lat = cur.lamps | {pins[9:0], 2'b00};
        lat[elc_pkg::L_DOOR] = lat[elc_pkg::L_DOOR] | req;
        lat[elc_pkg::L_F1IN] = lat[elc_pkg::L_F1IN] | pins[elc_pkg::PIN_F1IN];
    end

    assign f2_any = lat[elc_pkg::L_F2IN] | lat[elc_pkg::L_F2UP] | lat[elc_pkg::L_F2DN];

    // One step of the car controller
    always_comb
    begin
        nxt = cur;
        nxt.lamps = lat;
        case (cur.car_state)
            elc_pkg::ST_F3_CLOSED:
            begin
                if (lat[elc_pkg::L_F3IN] && lat[elc_pkg::L_F3DN])
                begin
                    nxt.lamps[elc_pkg::L_DOOR] = 1'b0;
                    nxt.car_state = elc_pkg::ST_F3_OPENING;
                end
                else if (lat[elc_pkg::L_DOOR])
                begin
                    nxt.lamps[elc_pkg::L_F3IN] = 1'b0;
                    nxt.lamps[elc_pkg::L_F3DN] = 1'b0;
                    nxt.car_state = elc_pkg::ST_F3_OPENING;
                end
                else if (lat[elc_pkg::L_F3IN])
                begin
                    nxt.lamps[elc_pkg::L_F3DN] = 1'b0;
                    nxt.car_state = elc_pkg::ST_F3_OPENING;
                end
                else if (lat[elc_pkg::L_F3DN])
                begin
                    nxt.lamps[elc_pkg::L_F3IN] = 1'b0;
                    nxt.car_state = elc_pkg::ST_F3_OPENING;
                end
                else if (lat[elc_pkg::L_F1IN] || lat[elc_pkg::L_F1UP] || f2_any)
                begin
                    nxt.car_state = elc_pkg::ST_DOWN_25;
                end
            end
            elc_pkg::ST_F2_CLOSED:
            begin
                if (lat[elc_pkg::L_F2IN] && lat[elc_pkg::L_F2DN] && lat[elc_pkg::L_F2UP])
                begin
                    nxt.lamps[elc_pkg::L_DOOR] = 1'b0;
                    nxt.car_state = elc_pkg::ST_F2_OPENING;
                end
                else if (lat[elc_pkg::L_DOOR])
                begin
                    nxt.lamps[elc_pkg::L_F2IN] = 1'b0;
                    nxt.lamps[elc_pkg::L_F2UP] = 1'b0;
                    nxt.lamps[elc_pkg::L_F2DN] = 1'b0;
                    nxt.car_state = elc_pkg::ST_F2_OPENING;
                end
                else if (lat[elc_pkg::L_F2IN])
                begin
                    nxt.lamps[elc_pkg::L_F2UP] = 1'b0;
                    nxt.lamps[elc_pkg::L_F2DN] = 1'b0;
                    nxt.car_state = elc_pkg::ST_F2_OPENING;
                end
                else if (lat[elc_pkg::L_F2DN])
                begin
                    nxt.lamps[elc_pkg::L_F2IN] = 1'b0;
                    nxt.lamps[elc_pkg::L_F2UP] = 1'b0;
                    nxt.car_state = elc_pkg::ST_F2_OPENING;
                end
                else if (lat[elc_pkg::L_F2UP])
                begin
                    nxt.lamps[elc_pkg::L_F2IN] = 1'b0;
                    nxt.lamps[elc_pkg::L_F2DN] = 1'b0;
                    nxt.car_state = elc_pkg::ST_F2_OPENING;
                end
                else if (lat[elc_pkg::L_F1IN] || lat[elc_pkg::L_F1UP])
                begin
                    nxt.car_state = elc_pkg::ST_DOWN_15;
                end
                else if (lat[elc_pkg::L_F3IN] || lat[elc_pkg::L_F3DN])
                begin
                    nxt.car_state = elc_pkg::ST_UP_25;
                end
            end
            elc_pkg::ST_F1_CLOSED:
            begin
                if (lat[elc_pkg::L_F1IN] && lat[elc_pkg::L_F1UP])
                begin
                    nxt.lamps[elc_pkg::L_DOOR] = 1'b0;
                    nxt.car_state = elc_pkg::ST_F1_OPENING;
                end
                else if (lat[elc_pkg::L_DOOR])
                begin
                    nxt.lamps[elc_pkg::L_F1IN] = 1'b0;
                    nxt.lamps[elc_pkg::L_F1UP] = 1'b0;
                    nxt.car_state = elc_pkg::ST_F1_OPENING;
                end
                else if (lat[elc_pkg::L_F1IN])
                begin
                    nxt.lamps[elc_pkg::L_F1UP] = 1'b0;
                    nxt.car_state = elc_pkg::ST_F1_OPENING;
                end
                else if (lat[elc_pkg::L_F1UP])
                begin
                    nxt.lamps[elc_pkg::L_F1IN] = 1'b0;
                    nxt.car_state = elc_pkg::ST_F1_OPENING;
                end
                else if (lat[elc_pkg::L_F3IN] || lat[elc_pkg::L_F3DN] || f2_any)
                begin
                    nxt.car_state = elc_pkg::ST_UP_15;
                end
            end
            // Door opening: drive the door until it reports done
            elc_pkg::ST_F3_OPENING, elc_pkg::ST_F2_OPENING, elc_pkg::ST_F1_OPENING:
            begin
                nxt.drive = elc_pkg::DRIVE_DOOR;
                if (done)
                begin
                    nxt.drive = elc_pkg::DRIVE_IDLE;
                    nxt.lamps[elc_pkg::L_DOOR] = 1'b0;
                    if (cur.car_state == elc_pkg::ST_F3_OPENING)
                    begin
                        nxt.lamps[elc_pkg::L_F3IN] = 1'b0;
                        nxt.lamps[elc_pkg::L_F3DN] = 1'b0;
                        nxt.car_state = elc_pkg::ST_F3_OPEN;
                    end
                    else if (cur.car_state == elc_pkg::ST_F2_OPENING)
                    begin
                        nxt.lamps[elc_pkg::L_F2IN] = 1'b0;
                        nxt.lamps[elc_pkg::L_F2UP] = 1'b0;
                        nxt.lamps[elc_pkg::L_F2DN] = 1'b0;
                        nxt.car_state = elc_pkg::ST_F2_OPEN;
                    end
                    else
                    begin
                        nxt.lamps[elc_pkg::L_F1IN] = 1'b0;
                        nxt.lamps[elc_pkg::L_F1UP] = 1'b0;
                        nxt.car_state = elc_pkg::ST_F1_OPEN;
                    end
                end
            end
            // Door closing: a door request reopens, done completes the close
            elc_pkg::ST_F3_CLOSING:
            begin
                if (req)
                    nxt.car_state = elc_pkg::ST_F3_OPENING;
                else if (done)
                    nxt.car_state = elc_pkg::ST_F3_CLOSED;
            end
            elc_pkg::ST_F2_CLOSING:
            begin
                if (req)
                    nxt.car_state = elc_pkg::ST_F2_OPENING;
                else if (done)
                    nxt.car_state = elc_pkg::ST_F2_CLOSED;
            end
            elc_pkg::ST_F1_CLOSING:
            begin
                if (req)
                    nxt.car_state = elc_pkg::ST_F1_OPENING;
                else if (done)
                    nxt.car_state = elc_pkg::ST_F1_CLOSED;
            end
            // Door open: hold for the programmed number of ticks
            elc_pkg::ST_F3_OPEN, elc_pkg::ST_F2_OPEN, elc_pkg::ST_F1_OPEN:
            begin
                if (cur.door_timer == door_hold)
                begin
                    nxt.drive      = elc_pkg::DRIVE_DOOR;
                    nxt.restarted  = 1'b0;
                    nxt.door_timer = '0;
                    if (cur.car_state == elc_pkg::ST_F3_OPEN)
                        nxt.car_state = elc_pkg::ST_F3_CLOSING;
                    else if (cur.car_state == elc_pkg::ST_F2_OPEN)
                        nxt.car_state = elc_pkg::ST_F2_CLOSING;
                    else
                        nxt.car_state = elc_pkg::ST_F1_CLOSING;
                end
                else if (cur.drive == elc_pkg::DRIVE_IDLE && !cur.restarted)
                begin
                    nxt.door_timer = '0;
                    nxt.restarted  = 1'b1;
                end
                else
                begin
                    nxt.door_timer = cur.door_timer + 1'b1;
                end
            end
            // Travel states; at mid-floor with nothing pending the car keeps moving
            elc_pkg::ST_DOWN_25:
            begin
                nxt.drive = elc_pkg::DRIVE_MOTOR;
                if (mid)
                begin
                    if (f2_any)
                    begin
                        nxt.car_state = elc_pkg::ST_F2_CLOSED;
                        nxt.drive     = elc_pkg::DRIVE_DOOR;
                    end
                    else if (lat[elc_pkg::L_F1IN] || lat[elc_pkg::L_F1UP])
                    begin
                        nxt.car_state = elc_pkg::ST_DOWN_15;
                    end
                end
            end
            elc_pkg::ST_DOWN_15:
            begin
                nxt.drive = elc_pkg::DRIVE_MOTOR;
                if (mid)
                begin
                    nxt.car_state = elc_pkg::ST_F1_CLOSED;
                    nxt.drive     = elc_pkg::DRIVE_IDLE;
                end
            end
            elc_pkg::ST_UP_15:
            begin
                nxt.drive = elc_pkg::DRIVE_MOTOR;
                if (mid)
                begin
                    if (f2_any)
                    begin
                        nxt.car_state = elc_pkg::ST_F2_CLOSED;
                        nxt.drive     = elc_pkg::DRIVE_IDLE;
                    end
                    else if (lat[elc_pkg::L_F3IN] || lat[elc_pkg::L_F3DN])
                    begin
                        nxt.car_state = elc_pkg::ST_UP_25;
                    end
                end
            end
            default:
            begin
                nxt.drive = elc_pkg::DRIVE_MOTOR;
                if (mid)
                begin
                    nxt.car_state = elc_pkg::ST_F3_CLOSED;
                    nxt.drive     = elc_pkg::DRIVE_IDLE;
                end
            end
        endcase
    end

endmodule

// ===== rtl/core/three_floor_elevator_controller.sv =====
// ----------------------------------------------------------------------------
// Three-floor elevator controller
// Takes one pin sample per tick, latches calls, steps the car controller and
// returns the lamp vector, drive latch and state for every tick.
//
//   Channel      Direction  Payload (lowest bit first)
//   s_axis_*     in         tdata[15:0] pin_sample
//   m_axis_*     out        tdata[11:0] lamp_bits, [13:12] drive_bits,
//                           [17:14] car_state_out, [23:18] zero
//   cfg_wr_*     in         door_hold_ticks, 16 bit, written when cfg_wr_en
//
// One sample per clock cycle is taken while the output is not stalled. A
// sample moves into the input register at its transfer, and its result is
// loaded from there into the result register, which presents it. The
// controller state advances when a sample moves from the input register into
// the result register. A stalled output holds both registers; s_axis_tready
// is high while the input register is empty or the result register can move.
// Reset puts the car at floor one with the door closed, all lamps off and the
// door hold at 5000 ticks.
// ----------------------------------------------------------------------------
module three_floor_elevator_controller (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [15:0]                 s_axis_tdata,  // [15:0] pin_sample
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [11:0] lamp_bits, [13:12] drive_bits, [17:14] car_state_out, [23:18] zero
    output logic [23:0]                 m_axis_tdata,
    input  logic                        cfg_wr_en,
    input  logic [elc_pkg::HOLD_W-1:0]  cfg_wr_data
);

    logic [elc_pkg::PIN_W-1:0]   pins_reg;
    logic                        pins_valid_reg;
    logic [elc_pkg::HOLD_W-1:0]  hold_reg;
    elc_pkg::ctrl_state_t        ctrl_reg;
    elc_pkg::ctrl_state_t        ctrl_next;
    logic                        out_valid_reg;
    logic [23:0]                 out_data_reg;
    logic [23:0]                 out_data_next;
    logic                        out_free;
    logic                        step_fire;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step_fire     = pins_valid_reg && out_free;
    assign s_axis_tready = !pins_valid_reg || out_free;

    // Door hold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_reg <= elc_pkg::HOLD_RESET;
        else if (cfg_wr_en)
            hold_reg <= cfg_wr_data;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pins_valid_reg <= 1'b0;
        else if (s_axis_tready)
            pins_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            pins_reg <= s_axis_tdata;
    end

    // Controller step
    elc_step u_step (
        .pins      (pins_reg),
        .door_hold (hold_reg),
        .cur       (ctrl_reg),
        .nxt       (ctrl_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctrl_reg <= elc_pkg::CTRL_RESET;
        else if (step_fire)
            ctrl_reg <= ctrl_next;
    end

    // Result register
    assign out_data_next = {6'b0, ctrl_next.car_state, ctrl_next.drive, ctrl_next.lamps};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= pins_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step_fire)
            out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ===== dv/elc_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Elevator controller checker
// Watches the pin, result and configuration channels of the controller and
// keeps its own model of the car. Every accepted pin sample yields one
// predicted result. Each result transfer is compared field by field with the
// oldest prediction. The mismatch count and the number of results still owed
// are handed to the testbench top.
// ----------------------------------------------------------------------------
module elc_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    input  logic                         s_axis_tready,
    input  logic [elc_pkg::PIN_W-1:0]    s_axis_tdata,
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    input  logic [23:0]                  m_axis_tdata,
    input  logic                         cfg_wr_en,
    input  logic [elc_pkg::HOLD_W-1:0]   cfg_wr_data,
    output int                           error_count,
    output int                           pending_count
);

    localparam int DRIVE_LSB = elc_pkg::LAMP_W;
    localparam int STATE_LSB = elc_pkg::LAMP_W + elc_pkg::DRIVE_W;
    localparam int PAD_LSB   = STATE_LSB + elc_pkg::STATE_W;

    typedef logic [elc_pkg::LAMP_W-1:0] lamp_t;

    typedef struct packed {
        lamp_t                        lamps;
        logic [elc_pkg::DRIVE_W-1:0]  drive;
        elc_pkg::car_state_t          car;
    } car_output_t;

    // Model of the car, updated once per accepted pin sample
    elc_pkg::car_state_t          car;
    lamp_t                        lamps;
    logic [elc_pkg::HOLD_W-1:0]   door_count;
    logic                         count_armed;
    logic [elc_pkg::DRIVE_W-1:0]  drive;
    logic [elc_pkg::HOLD_W-1:0]   hold_ticks;

    car_output_t pending_outputs [$];

    initial
    begin
        error_count   = 0;
        pending_count = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s, got %0h, expected %0h", $time, what, got, want);
        error_count++;
    endtask

    function automatic lamp_t lamp_bit(input int pos);
        return lamp_t'(1) << pos;
    endfunction

    // Serves the calls at the floor where the car stands. The inner call wins
    // over the down call, and the down call over the up call. Returns one
    // when the door is to open.
    function automatic logic serve_floor(input lamp_t in_m, input lamp_t dn_m,
                                         input lamp_t up_m);
        lamp_t calls;
        calls = in_m | dn_m | up_m;
        serve_floor = 1'b1;
        if ((lamps & calls) == calls)
            lamps[elc_pkg::L_DOOR] = 1'b0;
        else if (lamps[elc_pkg::L_DOOR])
            lamps = lamps & ~calls;
        else if ((lamps & in_m) != '0)
            lamps = lamps & ~(calls & ~in_m);
        else if ((lamps & dn_m) != '0)
            lamps = lamps & ~(calls & ~dn_m);
        else if ((lamps & up_m) != '0)
            lamps = lamps & ~(calls & ~up_m);
        else
            serve_floor = 1'b0;
    endfunction

    // The door motor runs until door done, which clears the served lamps.
    function automatic void open_door(input logic done, input lamp_t served,
                                      input elc_pkg::car_state_t next);
        drive = elc_pkg::DRIVE_DOOR;
        if (done)
        begin
            lamps = lamps & ~served;
            drive = elc_pkg::DRIVE_IDLE;
            car   = next;
        end
    endfunction

    // A door request while closing reopens; door done ends the closing.
    function automatic void shut_door(input logic req, input logic done,
                                      input elc_pkg::car_state_t reopen,
                                      input elc_pkg::car_state_t shut);
        if (req)
            car = reopen;
        else if (done)
            car = shut;
    endfunction

    // The open door is held until the counter meets the hold setting. The
    // counter restarts once on entry while the drive is idle.
    function automatic void hold_door(input elc_pkg::car_state_t next);
        if (door_count == hold_ticks)
        begin
            drive       = elc_pkg::DRIVE_DOOR;
            car         = next;
            count_armed = 1'b0;
            door_count  = '0;
        end
        else if (drive == elc_pkg::DRIVE_IDLE && !count_armed)
        begin
            door_count  = '0;
            count_armed = 1'b1;
        end
        else
        begin
            door_count = door_count + 1'b1;
        end
    endfunction

    // Advances the car by one tick and returns what the block should show.
    function automatic car_output_t step_car(input logic [elc_pkg::PIN_W-1:0] pins);
        car_output_t res;
        logic        done;
        logic        mid;
        lamp_t       f1_calls;
        lamp_t       f2_calls;
        lamp_t       f3_calls;
        done     = pins[elc_pkg::PIN_DONE];
        mid      = pins[elc_pkg::PIN_MID];
        f1_calls = lamp_bit(elc_pkg::L_F1IN) | lamp_bit(elc_pkg::L_F1UP);
        f2_calls = lamp_bit(elc_pkg::L_F2IN) | lamp_bit(elc_pkg::L_F2UP)
                 | lamp_bit(elc_pkg::L_F2DN);
        f3_calls = lamp_bit(elc_pkg::L_F3IN) | lamp_bit(elc_pkg::L_F3DN);

        // Calls latch on the tick they are seen; door done and midfloor never do.
        lamps = lamps | {pins[9:0], 2'b00};
        if (pins[elc_pkg::PIN_REQ])
            lamps[elc_pkg::L_DOOR] = 1'b1;
        if (pins[elc_pkg::PIN_F1IN])
            lamps[elc_pkg::L_F1IN] = 1'b1;

        case (car)
            elc_pkg::ST_F3_CLOSED:
            begin
                if (serve_floor(lamp_bit(elc_pkg::L_F3IN), lamp_bit(elc_pkg::L_F3DN), '0))
                    car = elc_pkg::ST_F3_OPENING;
                else if ((lamps & (f1_calls | f2_calls)) != '0)
                    car = elc_pkg::ST_DOWN_25;
            end
            elc_pkg::ST_F3_OPENING:
                open_door(done, lamp_bit(elc_pkg::L_DOOR) | f3_calls, elc_pkg::ST_F3_OPEN);
            elc_pkg::ST_F3_CLOSING:
                shut_door(pins[elc_pkg::PIN_REQ], done, elc_pkg::ST_F3_OPENING,
                          elc_pkg::ST_F3_CLOSED);
            elc_pkg::ST_F3_OPEN:
                hold_door(elc_pkg::ST_F3_CLOSING);
            elc_pkg::ST_F2_CLOSED:
            begin
                if (serve_floor(lamp_bit(elc_pkg::L_F2IN), lamp_bit(elc_pkg::L_F2DN),
                                lamp_bit(elc_pkg::L_F2UP)))
                    car = elc_pkg::ST_F2_OPENING;
                else if ((lamps & f1_calls) != '0)
                    car = elc_pkg::ST_DOWN_15;
                else if ((lamps & f3_calls) != '0)
                    car = elc_pkg::ST_UP_25;
            end
            elc_pkg::ST_F2_OPENING:
                open_door(done, lamp_bit(elc_pkg::L_DOOR) | f2_calls, elc_pkg::ST_F2_OPEN);
            elc_pkg::ST_F2_CLOSING:
                shut_door(pins[elc_pkg::PIN_REQ], done, elc_pkg::ST_F2_OPENING,
                          elc_pkg::ST_F2_CLOSED);
            elc_pkg::ST_F2_OPEN:
                hold_door(elc_pkg::ST_F2_CLOSING);
            elc_pkg::ST_F1_CLOSED:
            begin
                if (serve_floor(lamp_bit(elc_pkg::L_F1IN), '0, lamp_bit(elc_pkg::L_F1UP)))
                    car = elc_pkg::ST_F1_OPENING;
                else if ((lamps & (f2_calls | f3_calls)) != '0)
                    car = elc_pkg::ST_UP_15;
            end
            elc_pkg::ST_F1_OPENING:
                open_door(done, lamp_bit(elc_pkg::L_DOOR) | f1_calls, elc_pkg::ST_F1_OPEN);
            elc_pkg::ST_F1_CLOSING:
                shut_door(pins[elc_pkg::PIN_REQ], done, elc_pkg::ST_F1_OPENING,
                          elc_pkg::ST_F1_CLOSED);
            elc_pkg::ST_F1_OPEN:
                hold_door(elc_pkg::ST_F1_CLOSING);
            // Travel states: with no call ahead at midfloor the car keeps moving.
            elc_pkg::ST_DOWN_25:
            begin
                drive = elc_pkg::DRIVE_MOTOR;
                if (mid)
                begin
                    if ((lamps & f2_calls) != '0)
                    begin
                        car   = elc_pkg::ST_F2_CLOSED;
                        drive = elc_pkg::DRIVE_DOOR;
                    end
                    else if ((lamps & f1_calls) != '0)
                    begin
                        car = elc_pkg::ST_DOWN_15;
                    end
                end
            end
            elc_pkg::ST_DOWN_15:
            begin
                drive = elc_pkg::DRIVE_MOTOR;
                if (mid)
                begin
                    car   = elc_pkg::ST_F1_CLOSED;
                    drive = elc_pkg::DRIVE_IDLE;
                end
            end
            elc_pkg::ST_UP_15:
            begin
                drive = elc_pkg::DRIVE_MOTOR;
                if (mid)
                begin
                    if ((lamps & f2_calls) != '0)
                    begin
                        car   = elc_pkg::ST_F2_CLOSED;
                        drive = elc_pkg::DRIVE_IDLE;
                    end
                    else if ((lamps & f3_calls) != '0)
                    begin
                        car = elc_pkg::ST_UP_25;
                    end
                end
            end
            default:
            begin
                drive = elc_pkg::DRIVE_MOTOR;
                if (mid)
                begin
                    car   = elc_pkg::ST_F3_CLOSED;
                    drive = elc_pkg::DRIVE_IDLE;
                end
            end
        endcase

        res.lamps = lamps;
        res.drive = drive;
        res.car   = car;
        return res;
    endfunction

    // Result transfers are checked before the sample of the same edge is
    // modelled, since a result always belongs to an earlier sample.
    always @(posedge clk or negedge rst_n)
    begin : track
        car_output_t want;
        if (!rst_n)
        begin
            car         = elc_pkg::CTRL_RESET.car_state;
            lamps       = elc_pkg::CTRL_RESET.lamps;
            door_count  = elc_pkg::CTRL_RESET.door_timer;
            count_armed = elc_pkg::CTRL_RESET.restarted;
            drive       = elc_pkg::CTRL_RESET.drive;
            hold_ticks  = elc_pkg::HOLD_RESET;
            pending_outputs.delete();
            pending_count <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_outputs.size() == 0)
                begin
                    report_mismatch("result with none expected", 32'(m_axis_tdata), '0);
                end
                else
                begin
                    want = pending_outputs.pop_front();
                    if (m_axis_tdata[elc_pkg::LAMP_W-1:0] !== want.lamps)
                        report_mismatch("lamp_bits", 32'(m_axis_tdata[elc_pkg::LAMP_W-1:0]),
                                        32'(want.lamps));
                    if (m_axis_tdata[STATE_LSB-1:DRIVE_LSB] !== want.drive)
                        report_mismatch("drive_bits", 32'(m_axis_tdata[STATE_LSB-1:DRIVE_LSB]),
                                        32'(want.drive));
                    if (m_axis_tdata[PAD_LSB-1:STATE_LSB] !== want.car)
                        report_mismatch("car_state_out", 32'(m_axis_tdata[PAD_LSB-1:STATE_LSB]),
                                        32'(want.car));
                    if (m_axis_tdata[23:PAD_LSB] !== '0)
                        report_mismatch("padding", 32'(m_axis_tdata[23:PAD_LSB]), '0);
                end
            end
            if (cfg_wr_en)
                hold_ticks = cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready)
                pending_outputs.push_back(step_car(s_axis_tdata));
            pending_count <= pending_outputs.size();
        end
    end

endmodule

// ===== dv/tb_three_floor_elevator_controller.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Three-floor elevator controller testbench
// Drives pin samples into the controller under random idling on both sides,
// moves the door hold setting through zero, small values, 300 and the reset
// value, and leaves prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module tb_three_floor_elevator_controller;

    localparam int PHASE_ITEMS = 320;

    typedef logic [elc_pkg::PIN_W-1:0]  pins_t;
    typedef logic [elc_pkg::HOLD_W-1:0] hold_t;

    // Pin masks for the samples of the directed walk
    localparam pins_t P_DONE = pins_t'(1) << elc_pkg::PIN_DONE;
    localparam pins_t P_MID  = pins_t'(1) << elc_pkg::PIN_MID;
    localparam pins_t P_REQ  = pins_t'(1) << elc_pkg::PIN_REQ;
    localparam pins_t P_F1IN = pins_t'(1) << elc_pkg::PIN_F1IN;
    localparam pins_t P_F3IN = pins_t'(1) << (elc_pkg::L_F3IN - 2);
    localparam pins_t P_F2UP = pins_t'(1) << (elc_pkg::L_F2UP - 2);
    localparam pins_t P_F3DN = pins_t'(1) << (elc_pkg::L_F3DN - 2);

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    pins_t              s_axis_tdata = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [23:0]        m_axis_tdata;
    logic               cfg_wr_en = 1'b0;
    hold_t              cfg_wr_data = '0;

    int error_count;
    int pending_count;

    // Idling controls for the sender (tx_eager) and the receiver (rx_eager, rx_long_hold)
    bit tx_eager = 1'b0;
    bit rx_eager = 1'b0;
    int rx_long_hold = 0;

    // Walk through both door paths, travel in each direction and a reopen
    pins_t walk [0:23] = '{
        P_REQ | P_DONE, P_DONE, '0, P_DONE, P_F3IN, '0, P_MID, P_MID,
        '0, P_DONE, '0, P_DONE, P_F1IN, P_MID, P_F2UP, P_MID,
        '0, P_MID, '0, 16'hFFFF, '0, P_REQ, P_DONE | P_F3DN, 16'h0000
    };

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    three_floor_elevator_controller i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    elc_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    // Offers one sample after a drawn gap and returns at its transfer.
    task automatic send_pins(input pins_t pins);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pins;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // Stops offering and waits until every result has been taken.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_hold(input hold_t hold);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= hold;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Mostly sparse calls with frequent door done and midfloor, so the car
    // keeps moving; one sample in ten is plain noise.
    function automatic pins_t random_pins();
        pins_t pins;
        int    k;
        if ($urandom_range(0, 9) == 0)
            return pins_t'($urandom);
        pins = '0;
        for (k = 0; k < 10; k++)
            pins[k] = ($urandom_range(0, 15) == 0);
        pins[elc_pkg::PIN_DONE] = ($urandom_range(0, 2) == 0);
        pins[elc_pkg::PIN_MID]  = ($urandom_range(0, 2) == 0);
        pins[13:12]             = 2'($urandom_range(0, 3));
        pins[elc_pkg::PIN_REQ]  = ($urandom_range(0, 11) == 0);
        pins[elc_pkg::PIN_F1IN] = ($urandom_range(0, 15) == 0);
        return pins;
    endfunction

    // One setting of the door hold with random samples. A squeezed phase
    // stalls the receiver for a long stretch while samples keep coming, and
    // later pauses the sender until all results are in.
    task automatic random_phase(input hold_t hold, input bit squeeze);
        int k;
        set_hold(hold);
        for (k = 0; k < PHASE_ITEMS; k++)
        begin
            if (squeeze && k == PHASE_ITEMS / 4)
            begin
                rx_long_hold = 200;
                tx_eager     = 1'b1;
            end
            if (squeeze && k == PHASE_ITEMS / 4 + 60)
                tx_eager = 1'b0;
            if (squeeze && k == PHASE_ITEMS * 3 / 4)
                wait_drained();
            send_pins(random_pins());
        end
    endtask

    // Receiver: a drawn stall before each result transfer
    initial
    begin
        int gap;
        wait (rst_n);
        forever
        begin
            if (rx_long_hold > 0)
            begin
                gap          = rx_long_hold;
                rx_long_hold = 0;
            end
            else
            begin
                gap = rx_eager ? 0 : $urandom_range(0, 10);
            end
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // Stimulus and verdict
    initial
    begin
        int k;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Open the door at floor one under the reset hold.
        send_pins(P_REQ);
        send_pins(P_DONE);
        for (k = 0; k < 8; k++)
            send_pins('0);

        // A long hold: the counter runs up to the setting before closing.
        tx_eager = 1'b1;
        rx_eager = 1'b1;
        set_hold(16'd300);
        for (k = 0; k < 320; k++)
            send_pins('0);
        tx_eager = 1'b0;
        rx_eager = 1'b0;

        // Zero hold closes the door on the first tick of the open state.
        set_hold('0);
        for (k = 0; k < 24; k++)
            send_pins(walk[k]);

        random_phase(16'd1, 1'b0);
        tx_eager = 1'b1;
        rx_eager = 1'b1;
        random_phase(16'd3, 1'b0);
        tx_eager = 1'b0;
        rx_eager = 1'b0;
        random_phase(hold_t'($urandom_range(1, 10)), 1'b1);
        random_phase('0, 1'b0);
        tx_eager = 1'b1;
        random_phase(16'd2, 1'b0);
        tx_eager = 1'b0;

        wait_drained();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("tb_three_floor_elevator_controller: clean");
        else
            $display("tb_three_floor_elevator_controller: errors");
        $finish;
    end

    // Watchdog for a hung handshake
    initial
    begin
        #8_000_000;
        $display("tb_three_floor_elevator_controller: errors");
        $finish;
    end

endmodule
